>>> rtl/dtshs_pkg.sv
// Shared types, constants and lookup tables for the DTS header sync and decode block.
`default_nettype none

package dtshs_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned HdrW   = 32;
  localparam int unsigned ChanW  = 4;
  localparam int unsigned SrateW = 16;
  localparam int unsigned BrateW = 22;
  localparam int unsigned OutW   = 48;

  localparam logic [23:0] SyncPrefix = 24'h7ffe80;
  localparam logic [7:0]  SyncLast   = 8'h01;

  localparam logic [3:0] OffSyncEnd  = 4'd3;
  localparam logic [3:0] OffHdrFirst = 4'd7;
  localparam logic [3:0] OffHdrLast  = 4'd10;

  localparam logic [2:0] ExtIdXch = 3'd0;
  localparam logic [2:0] ExtIdX96 = 3'd3;
  localparam logic [1:0] LffOn1   = 2'd1;
  localparam logic [1:0] LffOn2   = 2'd2;

  // One parser event: found header or end-of-buffer miss.
  typedef struct packed {
    logic            found;
    logic [HdrW-1:0] hdr;
  } hdr_evt_t;

  function automatic logic [ChanW-1:0] chan_lut(input logic [3:0] amode);
    logic [ChanW-1:0] r;
    case (amode)
      4'd0:                      r = 4'd1;
      4'd1, 4'd2, 4'd3, 4'd4:    r = 4'd2;
      4'd5, 4'd6:                r = 4'd3;
      4'd7, 4'd8:                r = 4'd4;
      4'd9:                      r = 4'd5;
      4'd10, 4'd11, 4'd12:       r = 4'd6;
      4'd13:                     r = 4'd7;
      default:                   r = 4'd8;
    endcase
    return r;
  endfunction

  function automatic logic [SrateW-1:0] srate_lut(input logic [3:0] sfreq);
    logic [SrateW-1:0] r;
    case (sfreq)
      4'd1:    r = 16'd8000;
      4'd2:    r = 16'd16000;
      4'd3:    r = 16'd32000;
      4'd6:    r = 16'd11025;
      4'd7:    r = 16'd22050;
      4'd8:    r = 16'd44100;
      4'd11:   r = 16'd12000;
      4'd12:   r = 16'd24000;
      4'd13:   r = 16'd48000;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  // Bit rate in bits per second; codes past the table give zero.
  function automatic logic [BrateW-1:0] brate_lut(input logic [4:0] rate);
    logic [BrateW-1:0] r;
    case (rate)
      5'd0:    r = 22'd32000;
      5'd1:    r = 22'd56000;
      5'd2:    r = 22'd64000;
      5'd3:    r = 22'd96000;
      5'd4:    r = 22'd112000;
      5'd5:    r = 22'd128000;
      5'd6:    r = 22'd192000;
      5'd7:    r = 22'd224000;
      5'd8:    r = 22'd256000;
      5'd9:    r = 22'd320000;
      5'd10:   r = 22'd384000;
      5'd11:   r = 22'd448000;
      5'd12:   r = 22'd512000;
      5'd13:   r = 22'd576000;
      5'd14:   r = 22'd640000;
      5'd15:   r = 22'd768000;
      5'd16:   r = 22'd960000;
      5'd17:   r = 22'd1024000;
      5'd18:   r = 22'd1152000;
      5'd19:   r = 22'd1280000;
      5'd20:   r = 22'd1344000;
      5'd21:   r = 22'd1408000;
      5'd22:   r = 22'd1411000;
      5'd23:   r = 22'd1472000;
      5'd24:   r = 22'd1536000;
      5'd25:   r = 22'd1920000;
      5'd26:   r = 22'd2048000;
      5'd27:   r = 22'd3072000;
      5'd28:   r = 22'd3804000;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/dtshs_parser.sv
// Sync word search and header byte capture, one byte per accepted transaction.
`default_nettype none

module dtshs_parser (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  accept_i,
  input  wire logic [7:0]            byte_i,
  input  wire logic                  last_i,
  output logic                       evt_valid_o,
  output dtshs_pkg::hdr_evt_t        evt_o
);
  import dtshs_pkg::*;

  localparam logic [1:0] PhSearch  = 2'd0;
  localparam logic [1:0] PhCollect = 2'd1;
  localparam logic [1:0] PhDone    = 2'd2;
  localparam logic [1:0] PhSpare   = 2'd3;

  logic [23:0]     recent_q, recent_d;
  logic [1:0]      phase_q, phase_d;
  logic [3:0]      off_q, off_d;
  logic [HdrW-1:0] hdr_q, hdr_d;
  logic            hit;

  always_comb begin
    recent_d    = recent_q;
    phase_d     = phase_q;
    off_d       = off_q;
    hdr_d       = hdr_q;
    hit         = 1'b0;
    evt_valid_o = 1'b0;
    evt_o.found = 1'b0;
    evt_o.hdr   = '0;
    case (phase_q)
      PhSearch: begin
        if (recent_q == SyncPrefix && byte_i == SyncLast) begin
          phase_d = PhCollect;
          off_d   = OffSyncEnd;
          hdr_d   = '0;
        end
        recent_d = {recent_q[15:0], byte_i};
      end
      PhCollect: begin
        off_d = off_q + 4'd1;
        if (off_d >= OffHdrFirst && off_d <= OffHdrLast) begin
          hdr_d = {hdr_q[HdrW-9:0], byte_i};
        end
        if (off_d >= OffHdrLast) begin
          hit     = 1'b1;
          phase_d = PhDone;
        end
      end
      default: begin
        // done or spare code: drop bytes until the buffer ends
      end
    endcase

    if (hit) begin
      evt_valid_o = accept_i;
      evt_o.found = 1'b1;
      evt_o.hdr   = hdr_d;
    end else if (last_i && phase_d != PhDone && phase_d != PhSpare) begin
      evt_valid_o = accept_i;
    end

    if (last_i) begin
      recent_d = '0;
      phase_d  = PhSearch;
      off_d    = '0;
      hdr_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q <= '0;
      phase_q  <= PhSearch;
      off_q    <= '0;
      hdr_q    <= '0;
    end else if (accept_i) begin
      recent_q <= recent_d;
      phase_q  <= phase_d;
      off_q    <= off_d;
      hdr_q    <= hdr_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dtshs_decode.sv
// Field extraction and table lookup from the captured header bytes 7 to 10.
`default_nettype none

module dtshs_decode (
  input  dtshs_pkg::hdr_evt_t            evt_i,
  output logic [dtshs_pkg::ChanW-1:0]    chan_o,
  output logic [dtshs_pkg::SrateW-1:0]   srate_o,
  output logic [dtshs_pkg::BrateW-1:0]   brate_o
);
  import dtshs_pkg::*;

  logic [7:0]       b7, b8, b9, b10;
  logic [5:0]       amode;
  logic [3:0]       sfreq;
  logic [4:0]       rate;
  logic [2:0]       ext_id;
  logic             ext_on;
  logic [1:0]       lff;
  logic [ChanW-1:0] ch_base;
  logic             ext_inc, lfe_inc;

  always_comb begin
    b7     = evt_i.hdr[31:24];
    b8     = evt_i.hdr[23:16];
    b9     = evt_i.hdr[15:8];
    b10    = evt_i.hdr[7:0];
    amode  = {b7[3:0], b8[7:6]};
    sfreq  = b8[5:2];
    rate   = {b8[1:0], b9[7:5]};
    ext_id = b10[7:5];
    ext_on = b10[4];
    lff    = b10[2:1];

    ch_base = (amode[5:4] == 2'b00) ? chan_lut(amode[3:0]) : '0;
    ext_inc = ext_on && (ext_id == ExtIdXch || ext_id == ExtIdX96);
    lfe_inc = (lff == LffOn1) || (lff == LffOn2);

    if (evt_i.found) begin
      chan_o  = ch_base + ChanW'(ext_inc) + ChanW'(lfe_inc);
      srate_o = srate_lut(sfreq);
      brate_o = brate_lut(rate);
    end else begin
      chan_o  = '0;
      srate_o = '0;
      brate_o = '0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dts_header_sync_and_decode.sv
// DTS core frame header sync search and decode, top level with stream ports.
//
// Usage: feed a buffer one byte per transaction on the slave channel, with
// tlast on its final byte. The block hunts for the sync word 7F FE 80 01,
// captures header bytes 7 to 10 counted from the first sync byte and gives
// exactly one transaction per buffer on the master channel: tuser[0] high
// with channel count, sample rate and bit rate as soon as byte 10 arrives,
// or tuser[0] low with zero data on the tlast byte when no full header came.
// Bytes after a found header are dropped until tlast; no sync spans buffers.
// A result passes from the byte that completes it through the parser event
// register, then the result register, before it leaves the master port.
// Throughput: one byte per cycle; the only limit is the two-entry pipeline
// of event register and result register, which keeps taking bytes while a
// result waits, as long as the event slot is free.
// Reset clears the search history, the parse phase and both valid flags.
// When the receiver stalls, the result holds, then the event register
// fills and tready drops until the result is taken.
`default_nettype none

module dts_header_sync_and_decode (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave channel
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // end_of_buffer
  // master channel
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // [3:0] channel_count, [19:4] sample_rate_hz,
                                           // [41:20] bit_rate_bps, [47:42] zero
  output logic [0:0]       m_axis_tuser    // [0] header_found
);
  import dtshs_pkg::*;

  logic             in_acc;
  logic             evt_valid;
  hdr_evt_t         evt;

  // event register between parser and decoder
  logic             s1_valid_q, s1_valid_d;
  hdr_evt_t         s1_q;
  logic             s1_load;

  // result register
  logic             out_valid_q, out_valid_d;
  logic             out_free;
  logic             out_load;
  logic [ChanW-1:0] chan;
  logic [SrateW-1:0] srate;
  logic [BrateW-1:0] brate;
  logic [ChanW-1:0] chan_q;
  logic [SrateW-1:0] srate_q;
  logic [BrateW-1:0] brate_q;
  logic             found_q;

  // advance the event stage only when the result slot can take it
  assign out_free      = !out_valid_q || m_axis_tready;
  assign out_load      = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s1_load       = evt_valid;

  dtshs_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .byte_i      (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .evt_valid_o (evt_valid),
    .evt_o       (evt)
  );

  dtshs_decode u_decode (
    .evt_i   (s1_q),
    .chan_o  (chan),
    .srate_o (srate),
    .brate_o (brate)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (out_load) begin
      s1_valid_d = 1'b0;
    end
    if (s1_load) begin
      s1_valid_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers: hold the event until the result slot frees up
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_q <= evt;
    end
    if (out_load) begin
      found_q <= s1_q.found;
      chan_q  <= chan;
      srate_q <= srate;
      brate_q <= brate;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = found_q;
  assign m_axis_tdata  = {(OutW - ChanW - SrateW - BrateW)'(0), brate_q, srate_q, chan_q};

  // a miss carries all-zero data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("not-found result with nonzero data");

  // a found header never reports more than 10 channels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[3:0] <= 4'd10))
    else $error("channel count out of range");

  // a waiting event is not overwritten while the result slot is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> (s1_valid_q && $stable(s1_q)))
    else $error("event register lost while stalled");

  // the parser only raises an event for an accepted byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid |-> in_acc)
    else $error("event without accepted byte");

endmodule

`default_nettype wire
